/* src/hrrn_job_scheduler_top_defines.svh */
// Assertion helpers shared by the scheduler RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef HRRN_JOB_SCHEDULER_TOP_DEFINES_SVH
`define HRRN_JOB_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define HRRN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define HRRN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define HRRN_ASSERT(lbl, prop, msg)

`define HRRN_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

/* src/hrrn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrrn_pkg;

  localparam int unsigned SLOTS_DEF = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned SLOT_IN_W = 2;

  // Input word modes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_ARRIVE = 1'b1;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  dividend;
    logic [BURST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TIME_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/hrrn_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module hrrn_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrrn_pkg::div_req_t req_i,
  output hrrn_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned TW    = hrrn_pkg::TIME_W;
  localparam int unsigned BW    = hrrn_pkg::BURST_W;
  localparam int unsigned CNT_W = $clog2(TW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TW-1:0]    quo_q;
  logic [BW-1:0]    rem_q;
  logic [BW-1:0]    dvs_q;

  logic [BW:0]   trial;
  logic [BW:0]   diff;
  logic          fits;
  logic [BW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, quo_q[TW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[BW-1:0] : trial[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(TW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift one bit per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[TW-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* src/hrrn_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Per-slot burst and arrival store: one write port, one registered read port.
module hrrn_slot_mem #(
  parameter int unsigned SLOTS = hrrn_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(SLOTS)-1:0]      waddr_i,
  input  wire logic [hrrn_pkg::BURST_W-1:0]  wburst_i,
  input  wire logic [hrrn_pkg::TIME_W-1:0]   warrival_i,
  input  wire logic [$clog2(SLOTS)-1:0]      raddr_i,
  output logic      [hrrn_pkg::BURST_W-1:0]  rburst_o,
  output logic      [hrrn_pkg::TIME_W-1:0]   rarrival_o
);

  localparam int unsigned EW = hrrn_pkg::BURST_W + hrrn_pkg::TIME_W;

  logic [EW-1:0] mem_q [SLOTS];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wburst_i, warrival_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr_i];
  end

  assign rburst_o   = rd_q[EW-1:hrrn_pkg::TIME_W];
  assign rarrival_o = rd_q[hrrn_pkg::TIME_W-1:0];

endmodule

`default_nettype wire

/* src/hrrn_job_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted word goes through ST_CHECK straight to ST_EMIT when no selection is
//   needed (a job runs or no slot waits); a selection visits ST_READ for every slot and, for
//   each waiting slot, a table read, a divider load and a full divide before ST_PICK.
// Throughput: one word at a time, with each divide done by the shared one-bit-per-cycle
//   divider; a new word is taken while the last result waits.
// Reset: rst_ni asynchronous, active low; clears time, run state and waiting flags.

`include "hrrn_job_scheduler_top_defines.svh"

module hrrn_job_scheduler_top #(
  parameter int unsigned SLOTS = hrrn_pkg::SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [hrrn_pkg::SLOT_IN_W-1:0]  slot_i,
  input  wire logic [hrrn_pkg::BURST_W-1:0]    burst_length_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 busy_res_o,
  output logic      [hrrn_pkg::SLOT_IN_W-1:0]  running_slot_o,
  output logic                                 done_res_o,
  output logic      [hrrn_pkg::TIME_W-1:0]     finish_time_o,
  output logic                                 rejected_o
);

  localparam int unsigned TW = hrrn_pkg::TIME_W;
  localparam int unsigned BW = hrrn_pkg::BURST_W;
  localparam int unsigned SW = hrrn_pkg::SLOT_IN_W;
  localparam int unsigned IW = $clog2(SLOTS);
  // common width for moving between the port slot field and the slot index
  localparam int unsigned XW = (IW > SW) ? IW : SW;

  typedef enum logic [2:0] {
    ST_IDLE,      // wait for an input word
    ST_CHECK,     // decide whether a selection is needed
    ST_READ,      // read the table entry of the scanned slot
    ST_DIV_START, // load the divider with wait and burst
    ST_DIV_WAIT,  // wait for the ratio, then compare against the best
    ST_PICK,      // start the winning job
    ST_EMIT       // hand the result to the output register
  } state_e;

  state_e state_q;

  // Scheduler state
  logic [TW-1:0]    now_q;
  logic             run_active_q;
  logic [IW-1:0]    run_slot_q;
  logic [BW-1:0]    run_left_q;
  logic [SLOTS-1:0] waiting_q;

  // Per-word result bookkeeping
  logic             done_q;
  logic [IW-1:0]    done_slot_q;
  logic [TW-1:0]    finish_q;
  logic             rej_q;

  // Selection scan
  logic [IW-1:0]    idx_q;
  logic             found_q;
  logic [IW-1:0]    best_q;
  logic [TW-1:0]    best_ratio_q;
  logic [BW-1:0]    best_burst_q;
  logic [BW-1:0]    cand_burst_q;

  // Output register
  logic             out_valid_q;
  logic             busy_out_q;
  logic [SW-1:0]    slot_out_q;
  logic             done_out_q;
  logic [TW-1:0]    finish_out_q;
  logic             rej_out_q;

  // Arrival decode
  logic             accept;
  logic [XW-1:0]    slot_x;
  logic [IW-1:0]    slot_idx;
  logic             slot_in_range;
  logic             slot_occupied;
  logic             arrive_rej;
  logic             mem_we;
  logic [BW-1:0]    burst_w;

  // Tick decode
  logic [TW-1:0]    now_inc;
  logic [BW-1:0]    left_dec;

  // Table read and divider
  logic [BW-1:0]    rd_burst;
  logic [TW-1:0]    rd_arrival;
  hrrn_pkg::div_req_t div_req;
  hrrn_pkg::div_rsp_t div_rsp;

  // Ratio compare
  logic [TW-1:0]    cand_ratio;
  logic             cand_better;

  // Result slot fields
  logic [IW-1:0]    res_slot;
  logic [XW-1:0]    res_slot_x;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    slot_x        = XW'(slot_i);
    slot_idx      = slot_x[IW-1:0];
    slot_in_range = (32'(slot_i) < SLOTS);
    slot_occupied = waiting_q[slot_idx] || (run_active_q && (run_slot_q == slot_idx));
    arrive_rej    = !slot_in_range || slot_occupied;
    // a zero burst counts as one tick
    burst_w       = (burst_length_i == '0) ? BW'(1) : burst_length_i;
    mem_we        = accept && (mode_i == hrrn_pkg::MODE_ARRIVE) && !arrive_rej;
    now_inc       = now_q + 1'b1;
    left_dec      = run_left_q - 1'b1;
  end

  hrrn_slot_mem #(
    .SLOTS (SLOTS)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .we_i       (mem_we),
    .waddr_i    (slot_idx),
    .wburst_i   (burst_w),
    .warrival_i (now_q),
    .raddr_i    (idx_q),
    .rburst_o   (rd_burst),
    .rarrival_o (rd_arrival)
  );

  // Wait is taken modulo 2^32, so a wrapped clock still gives the right age
  always_comb begin
    div_req.start    = (state_q == ST_DIV_START);
    div_req.dividend = now_q - rd_arrival;
    div_req.divisor  = rd_burst;
  end

  hrrn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Ratio is 1 + quotient, wrapping to zero when the quotient is all ones.
  // Ties go to the longer burst; equal bursts keep the earlier (lower) slot.
  always_comb begin
    cand_ratio  = div_rsp.quotient + 1'b1;
    cand_better = !found_q || (cand_ratio > best_ratio_q) ||
                  ((cand_ratio == best_ratio_q) && (cand_burst_q > best_burst_q));
  end

  // On a finish the finished slot is reported, else the running one, else zero
  always_comb begin
    if (done_q) begin
      res_slot = done_slot_q;
    end else if (run_active_q) begin
      res_slot = run_slot_q;
    end else begin
      res_slot = '0;
    end
    res_slot_x = XW'(res_slot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      now_q        <= '0;
      run_active_q <= 1'b0;
      run_slot_q   <= '0;
      run_left_q   <= '0;
      waiting_q    <= '0;
      done_q       <= 1'b0;
      done_slot_q  <= '0;
      finish_q     <= '0;
      rej_q        <= 1'b0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      best_q       <= '0;
      best_ratio_q <= '0;
      best_burst_q <= '0;
      cand_burst_q <= '0;
      out_valid_q  <= 1'b0;
      busy_out_q   <= 1'b0;
      slot_out_q   <= '0;
      done_out_q   <= 1'b0;
      finish_out_q <= '0;
      rej_out_q    <= 1'b0;
    end else begin
      // drop the result once it is taken; a new load below wins
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            done_q   <= 1'b0;
            finish_q <= '0;
            rej_q    <= 1'b0;
            if (mode_i == hrrn_pkg::MODE_ARRIVE) begin
              // occupied or out-of-range slot: flag it and change nothing
              rej_q <= arrive_rej;
              if (!arrive_rej) begin
                waiting_q[slot_idx] <= 1'b1;
              end
            end else begin
              // advance time and count down the running job
              now_q <= now_inc;
              if (run_active_q) begin
                run_left_q <= left_dec;
                if (left_dec == '0) begin
                  done_q       <= 1'b1;
                  done_slot_q  <= run_slot_q;
                  finish_q     <= now_inc;
                  run_active_q <= 1'b0;
                end
              end
            end
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (!run_active_q && (|waiting_q)) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= ST_READ;
          end else begin
            state_q <= ST_EMIT;
          end
        end

        ST_READ: begin
          // empty slots are skipped without touching the divider
          if (waiting_q[idx_q]) begin
            state_q <= ST_DIV_START;
          end else if (idx_q == IW'(SLOTS - 1)) begin
            state_q <= ST_PICK;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        ST_DIV_START: begin
          cand_burst_q <= rd_burst;
          state_q      <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (cand_better) begin
              found_q      <= 1'b1;
              best_q       <= idx_q;
              best_ratio_q <= cand_ratio;
              best_burst_q <= cand_burst_q;
            end
            if (idx_q == IW'(SLOTS - 1)) begin
              state_q <= ST_PICK;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end

        ST_PICK: begin
          if (found_q) begin
            waiting_q[best_q] <= 1'b0;
            run_active_q      <= 1'b1;
            run_slot_q        <= best_q;
            run_left_q        <= best_burst_q;
          end
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          // hold until the output register is free or being emptied
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            busy_out_q   <= run_active_q;
            slot_out_q   <= res_slot_x[SW-1:0];
            done_out_q   <= done_q;
            finish_out_q <= finish_q;
            rej_out_q    <= rej_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign busy_res_o     = busy_out_q;
  assign running_slot_o = slot_out_q;
  assign done_res_o     = done_out_q;
  assign finish_time_o  = finish_out_q;
  assign rejected_o     = rej_out_q;

  `HRRN_ASSERT(a_run_not_waiting, run_active_q |-> !waiting_q[run_slot_q], "running slot still flagged waiting")
  `HRRN_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `HRRN_ASSERT_NEXT(a_pick_starts_job, (state_q == ST_PICK) && found_q, run_active_q, "selected job not started")
  `HRRN_ASSERT(a_done_not_rejected, out_valid_o && rejected_o |-> !done_res_o, "rejected arrival reports a finish")

endmodule

`default_nettype wire
